FILE: rtl/mssd_pkg.sv
// ----------------------------------------------------------------------------
// mssd_pkg
// Shared types, constants and helpers for the fewest-squares core.
// ----------------------------------------------------------------------------
`default_nettype none

package mssd_pkg;

  localparam int TARGET_W = 12;
  localparam int COUNT_W  = 3;

  // Count marks held in the scratch table
  localparam logic [COUNT_W-1:0] COUNT_ZERO = 3'd0;
  localparam logic [COUNT_W-1:0] INF_MARK   = 3'd7;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch target, reset counters
    logic init_step;   // write one table entry with its start value
    logic pass_step;   // issue one read-modify-write of the current pass
    logic final_read;  // issue the read of the answer entry
    logic capture;     // latch the answer entry
    logic emit;        // move the answer into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic init_last;   // current init step writes the target entry
    logic pass_done;   // next square lies above the target
  } status_t;

  // One plus a count, held at the infinity mark
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v >= INF_MARK) ? INF_MARK : v + COUNT_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mssd_datapath.sv
// ----------------------------------------------------------------------------
// mssd_datapath
// Scratch table, index counters and the two-stage read-modify-write path.
// ----------------------------------------------------------------------------
`default_nettype none

module mssd_datapath #(
  parameter int MAX_TARGET = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [mssd_pkg::TARGET_W-1:0] target,
  input  wire mssd_pkg::cmd_t                cmd,
  output mssd_pkg::status_t                  status,
  output logic [mssd_pkg::COUNT_W-1:0]       square_count
);

  import mssd_pkg::*;

  localparam int AW = $clog2(MAX_TARGET);
  localparam int SW = AW + 2;
  localparam int RW = AW / 2 + 2;
  localparam int CW = ((AW > TARGET_W) ? AW : TARGET_W) + 1;

  logic [COUNT_W-1:0] count_mem [MAX_TARGET];

  logic [AW-1:0]      tgt;
  logic [AW-1:0]      idx;
  logic [SW-1:0]      sq;
  logic [RW-1:0]      root;
  logic [AW-1:0]      rd_a;
  logic [AW-1:0]      rd_b;
  logic [COUNT_W-1:0] q_a;
  logic [COUNT_W-1:0] q_b;
  logic [AW-1:0]      s1_a;
  logic [AW-1:0]      s1_b;
  logic               s1_valid;
  logic [AW-1:0]      wl_addr;
  logic [COUNT_W-1:0] wl_data;
  logic               wl_valid;
  logic [COUNT_W-1:0] result;

  logic [CW-1:0]      tgt_wide;
  logic [AW-1:0]      tgt_next;
  logic [COUNT_W-1:0] fwd_a;
  logic [COUNT_W-1:0] fwd_b;
  logic [COUNT_W-1:0] cand;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [COUNT_W-1:0] wdata;
  logic               step_last;

  // Clamp the target into the table
  always_comb begin
    tgt_wide = CW'(target);
    if (tgt_wide >= CW'(MAX_TARGET)) begin
      tgt_next = AW'(MAX_TARGET - 1);
    end else begin
      tgt_next = tgt_wide[AW-1:0];
    end
  end

  // Read addresses: lower entry and updated entry, or the answer entry
  assign rd_b      = sq[AW-1:0] + idx;
  assign rd_a      = cmd.final_read ? tgt : idx;
  assign step_last = (rd_b == tgt);

  assign status.init_last = (idx == tgt);
  assign status.pass_done = (sq > SW'(tgt));

  // Forward the write that landed at the same edge as the read
  assign fwd_a = (wl_valid && wl_addr == s1_a) ? wl_data : q_a;
  assign fwd_b = (wl_valid && wl_addr == s1_b) ? wl_data : q_b;
  assign cand  = sat_inc(fwd_a);

  // Write port: start values during init, relaxed entry during passes
  always_comb begin
    if (cmd.init_step) begin
      we    = 1'b1;
      waddr = idx;
      wdata = (idx == '0) ? COUNT_ZERO : INF_MARK;
    end else begin
      we    = s1_valid;
      waddr = s1_b;
      wdata = (cand < fwd_b) ? cand : fwd_b;
    end
  end

  // Scratch table
  always_ff @(posedge clk) begin
    if (we) begin
      count_mem[waddr] <= wdata;
    end
    q_a <= count_mem[rd_a];
    q_b <= count_mem[rd_b];
  end

  // Pipeline and forwarding control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wl_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.pass_step;
      wl_valid <= we;
    end
  end

  // Payload of the pipeline
  always_ff @(posedge clk) begin
    s1_a    <= rd_a;
    s1_b    <= rd_b;
    wl_addr <= waddr;
    wl_data <= wdata;
  end

  // Advance counters
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      sq   <= '0;
      root <= '0;
    end else if (cmd.load) begin
      idx  <= '0;
      sq   <= SW'(1);
      root <= RW'(1);
    end else if (cmd.init_step) begin
      idx <= status.init_last ? '0 : idx + AW'(1);
    end else if (cmd.pass_step) begin
      if (step_last) begin
        idx  <= '0;
        sq   <= sq + SW'({root, 1'b1});
        root <= root + RW'(1);
      end else begin
        idx <= idx + AW'(1);
      end
    end
  end

  // Hold target, answer and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt <= tgt_next;
    end
    if (cmd.capture) begin
      result <= fwd_a;
    end
    if (cmd.emit) begin
      square_count <= result;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mssd_ctrl.sv
// ----------------------------------------------------------------------------
// mssd_ctrl
// Sequencer for one query: table init, square passes, answer read, output.
// ----------------------------------------------------------------------------
`default_nettype none

module mssd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mssd_pkg::cmd_t         cmd,
  input  wire mssd_pkg::status_t status
);

  import mssd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_PASS,
    S_FINAL,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (status.init_last) begin
          state_next = S_PASS;
        end
      end
      S_PASS: begin
        if (status.pass_done) begin
          cmd.final_read = 1'b1;
          state_next     = S_FINAL;
        end else begin
          cmd.pass_step = 1'b1;
        end
      end
      S_FINAL: begin
        cmd.capture = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.emit)
    else $error("output register overwritten while stalled");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> in_stall)
    else $error("input taken again right after a load");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted item not presented");

endmodule

`default_nettype wire

FILE: rtl/min_squares_sum_dp_core.sv
// ----------------------------------------------------------------------------
// min_squares_sum_dp_core
// Fewest perfect squares summing to a target, by table relaxation.
// ----------------------------------------------------------------------------
// One item at a time. A query for target t (clamped to MAX_TARGET-1) runs a
// table init, one relaxation pass per square r*r <= t and the answer read,
// then waits while the previous count is still held by out_stall.
// The scratch table's single write port sets the pace: one entry is
// initialized or relaxed per cycle, with same-cycle forwarding so that each
// relaxation follows the next without a bubble. The result waits in an output
// register, so a new target is accepted while the previous count is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module min_squares_sum_dp_core #(
  parameter int MAX_TARGET = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mssd_pkg::TARGET_W-1:0] target,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mssd_pkg::COUNT_W-1:0]       square_count
);

  import mssd_pkg::*;

  cmd_t    cmd;
  status_t status;

  mssd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  mssd_datapath #(
    .MAX_TARGET (MAX_TARGET)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .target       (target),
    .cmd          (cmd),
    .status       (status),
    .square_count (square_count)
  );

endmodule

`default_nettype wire

FILE: tb/tb_min_squares_sum_dp_core.sv
// ----------------------------------------------------------------------------
// tb_min_squares_sum_dp_core
// Self-checking bench for the fewest-squares core.
// ----------------------------------------------------------------------------
// A queue of targets feeds a clocked driver. Each accepted target is run
// through a local table relaxation to get the expected count. A clocked
// monitor checks every count that leaves the core against the oldest
// expected one. Both sides idle at random. One stretch on each side runs with no idling.
// The receiver also holds off once for a long time, so the core backs up
// and stalls its input. Most targets are small to keep the run short. A few
// large ones set the top bits of the target.
// ----------------------------------------------------------------------------

module tb_min_squares_sum_dp_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mssd_pkg::*;

  localparam int MAX_TARGET   = 4096;
  localparam int RANDOM_ITEMS = 80;
  localparam int IDLE_PCT     = 33;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 12000;
  localparam int DRAIN_CYCLES = 200;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [TARGET_W-1:0] target = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [COUNT_W-1:0]  square_count;

  logic [TARGET_W-1:0] target_queue[$];
  logic [COUNT_W-1:0]  count_due[$];
  logic [COUNT_W-1:0]  due_count;

  int    total_items = 0;
  int    sent_count = 0;
  int    recv_count = 0;
  int    fail_count = 0;
  int    stall_cycles = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;
  int    largest = 0;
  longint cycle_count = 0;
  longint cycle_limit = 64'd100_000_000;

  min_squares_sum_dp_core #(
    .MAX_TARGET(MAX_TARGET)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .target      (target),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .square_count(square_count)
  );

  // Fewest squares for one target: relax a 3-bit table, saturating at infinity
  function automatic logic [COUNT_W-1:0] fewest_squares(input logic [TARGET_W-1:0] t_in);
    logic [COUNT_W-1:0] tbl [0:MAX_TARGET-1];
    logic [COUNT_W-1:0] cand;
    int t;
    int r;
    int j;
    t = (int'(t_in) >= MAX_TARGET) ? MAX_TARGET - 1 : int'(t_in);
    tbl[0] = COUNT_ZERO;
    for (j = 1; j <= t; j++) tbl[j] = INF_MARK;
    for (r = 1; r * r <= t; r++) begin
      for (j = 0; r * r + j <= t; j++) begin
        cand = (tbl[j] >= INF_MARK) ? INF_MARK : tbl[j] + COUNT_W'(1);
        if (cand < tbl[r * r + j]) tbl[r * r + j] = cand;
      end
    end
    return tbl[t];
  endfunction

  // Free-running clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("tb_min_squares_sum_dp_core: done, errors");
      $finish;
    end
  end

  // Drive targets; predict the count of each accepted item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) stall_cycles++;
      if (in_valid && !in_stall) begin
        count_due.push_back(fewest_squares(target));
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (target_queue.size() > 0 &&
            ((sent_count >= 40 && sent_count < 65) || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          target   <= target_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check counts in order; stall at random, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        recv_count++;
        if (count_due.size() == 0) begin
          $error("square_count: no count expected, actual %0d", square_count);
          fail_count++;
        end else begin
          due_count = count_due.pop_front();
          if (square_count !== due_count) begin
            $error("square_count: expected %0d, actual %0d", due_count, square_count);
            fail_count++;
          end
        end
      end
      if (!hold_done && recv_count >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_count >= 70 && recv_count < 95) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Build the stimulus, run it, and report
  initial begin
    logic [TARGET_W-1:0] directed[$];
    longint budget;
    int t;
    int r;
    int i;
    budget = 0;

    // Field extremes, tiny targets, every count from 0 to 4, alternating bits
    directed = '{0, 1, 2, 3, 4, 5, 7, 12, 13, 15, 16, 28, 31, 63, 64, 127,
                 255, 256, 1365, 2730, 4095};
    foreach (directed[k]) target_queue.push_back(directed[k]);

    // Random targets: mostly small, a couple large
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 25 || i == 65) target_queue.push_back(TARGET_W'($urandom_range(2048, 4095)));
      else if (i % 8 == 0) target_queue.push_back(TARGET_W'($urandom_range(0, 40)));
      else target_queue.push_back(TARGET_W'($urandom_range(0, 300)));
    end
    total_items = target_queue.size();

    // Size the timeout from the core's per-query cycle count
    foreach (target_queue[k]) begin
      t = int'(target_queue[k]);
      if (t > largest) largest = t;
      budget += 8 + t + 1;
      for (r = 1; r * r <= t; r++) budget += t - r * r + 1;
    end
    cycle_limit = 4 * budget + HOLD_CYCLES + 100000;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to go in and every count to come back
    while (sent_count < total_items || count_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d targets up to %0d, %0d counts checked", total_items, largest,
             recv_count);
    $display("input stalled for %0d cycles, including a %0d-cycle receiver hold-off",
             stall_cycles, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("tb_min_squares_sum_dp_core: done, clean");
    end else begin
      $display("tb_min_squares_sum_dp_core: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mssd_pkg.sv
rtl/mssd_datapath.sv
rtl/mssd_ctrl.sv
rtl/min_squares_sum_dp_core.sv
tb/tb_min_squares_sum_dp_core.sv
